### hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the first-fit heap allocator.
// No dependencies; used by scoped name from ffha_req_check and the core.
package ffha_pkg;

  // Raw header size in bytes before rounding up to a granule
  localparam int HeaderRawBytes = 8;

  // Request kinds carried on in_tuser
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SET,
    ST_A_SPL,
    ST_A_WCUR,
    ST_F_RD,
    ST_F_CHK,
    ST_F_WHDR,
    ST_I_WALK,
    ST_I_LD,
    ST_I_MRG,
    ST_I_NXT,
    ST_I_NXM,
    ST_I_WBLK,
    ST_I_WIT
  } state_t;

  // Request screening flags from the check unit
  typedef struct packed {
    logic alloc_bad;
    logic free_bad;
  } req_chk_t;

endpackage

### hw/rtl/ffha_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ffha_req_check.sv
`timescale 1ns / 1ps
// Request screening: granule count of an allocate, header index of a free.
// Depends on ffha_pkg.
module ffha_req_check #(
  parameter int HEAP_BYTES    = 16384,
  parameter int GRANULE_BYTES = 8
) (
  input  logic [15:0]                                   request_bytes,
  input  logic [13:0]                                   release_offset,
  output logic [$clog2(HEAP_BYTES/GRANULE_BYTES):0]     need,
  output logic [$clog2(HEAP_BYTES/GRANULE_BYTES)-1:0]   hdr,
  output ffha_pkg::req_chk_t                            chk
);

  localparam int GranuleCount = HEAP_BYTES / GRANULE_BYTES;
  localparam int GW  = $clog2(GranuleCount);
  localparam int LW  = GW + 1;
  localparam int LGG = $clog2(GRANULE_BYTES);
  localparam int HeaderBytes =
    ((ffha_pkg::HeaderRawBytes + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;

  logic [31:0] need_full;
  logic [31:0] rel_full;
  logic [31:0] hdr_full;

  always_comb begin
    need_full = (32'(request_bytes) + 32'(HeaderBytes + GRANULE_BYTES - 1)) >> LGG;
    need      = need_full[LW-1:0];
    rel_full  = 32'(release_offset) - 32'(HeaderBytes);
    hdr_full  = rel_full >> LGG;
    hdr       = hdr_full[GW-1:0];
    chk.alloc_bad = (request_bytes == 16'd0) ||
                    (32'(request_bytes) >= 32'(HEAP_BYTES));
    chk.free_bad  = (32'(release_offset) < 32'(HeaderBytes)) ||
                    ((rel_full & 32'(GRANULE_BYTES - 1)) != 32'd0) ||
                    (hdr_full >= 32'(GranuleCount));
  end

endmodule

### hw/rtl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// First-fit heap allocator core: free-list walker over one header RAM.
// One word at a time: the next word is taken only after the result of the last one
//   has been accepted on out_tready and the sequencer is back in ST_IDLE.
// Reset: synchronous, active low; a clearing pass writes every header before the first
//   word is taken.
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES    = 16384,
  parameter int GRANULE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] request_bytes, [29:16] release_offset, zero pad
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [13:0] granted_offset, zero pad
  output logic        out_tuser   // [0] ok
);

  localparam int GranuleCount = HEAP_BYTES / GRANULE_BYTES;
  localparam int GW  = $clog2(GranuleCount);
  localparam int LW  = GW + 1;
  localparam int DW  = 2 * LW + 1;
  localparam int LGG = $clog2(GRANULE_BYTES);
  localparam int HeaderBytes =
    ((ffha_pkg::HeaderRawBytes + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam int HeaderGranules = HeaderBytes / GRANULE_BYTES;
  localparam int EndGranule = (HEAP_BYTES - ffha_pkg::HeaderRawBytes) / GRANULE_BYTES;
  localparam int MinSplit = 2 * HeaderGranules;

  // Links are one bit wider than a header index; all ones marks the empty link
  localparam logic [LW-1:0] LINK_EMPTY = '1;
  localparam logic [LW-1:0] END_LINK   = LW'(EndGranule);

  ffha_pkg::state_t state_r, state_nxt;

  logic [GW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0] list_head_r, list_head_nxt;
  logic [LW-1:0] need_r, need_nxt;
  logic [GW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] cur_g_r, cur_g_nxt;
  logic [LW-1:0] cur_link_r, cur_link_nxt;
  logic          prev_head_r, prev_head_nxt;
  logic [GW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] prev_g_r, prev_g_nxt;
  logic          prev_use_r, prev_use_nxt;
  logic [GW-1:0] blk_r, blk_nxt;
  logic [LW-1:0] bg_r, bg_nxt;
  logic          it_head_r, it_head_nxt;
  logic [GW-1:0] it_r, it_nxt;
  logic [LW-1:0] it_g_r, it_g_nxt;
  logic          it_use_r, it_use_nxt;
  logic [LW-1:0] nx_r, nx_nxt;
  logic [LW-1:0] link_b_r, link_b_nxt;
  logic          merged_r, merged_nxt;
  logic          split_r, split_nxt;
  logic [13:0]   granted_r, granted_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [13:0]   oofs_r, oofs_nxt;
  logic          ook_r, ook_nxt;

  // Header RAM port: word is {in_use, link, granules}
  logic          ram_we;
  logic          ram_re;
  logic [GW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic          rd_use;
  logic [LW-1:0] rd_link;
  logic [LW-1:0] rd_g;

  logic [LW-1:0] chk_need;
  logic [GW-1:0] chk_hdr;
  ffha_pkg::req_chk_t chk;

  logic [LW-1:0] rem_g;
  logic [LW:0]   sum_a;
  logic [LW:0]   sum_b;
  logic [31:0]   ofs_full;

  assign rd_use  = ram_rdata[DW-1];
  assign rd_link = ram_rdata[2*LW-1:LW];
  assign rd_g    = ram_rdata[LW-1:0];

  ffha_req_check #(
    .HEAP_BYTES   (HEAP_BYTES),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_check (
    .request_bytes (in_tdata[15:0]),
    .release_offset(in_tdata[29:16]),
    .need          (chk_need),
    .hdr           (chk_hdr),
    .chk           (chk)
  );

  ffha_ram #(
    .WIDTH(DW),
    .DEPTH(GranuleCount)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ffha_pkg::ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, oofs_r};
  assign out_tuser  = ook_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      list_head_r <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      list_head_r <= list_head_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    cur_r       <= cur_nxt;
    cur_g_r     <= cur_g_nxt;
    cur_link_r  <= cur_link_nxt;
    prev_head_r <= prev_head_nxt;
    prev_r      <= prev_nxt;
    prev_g_r    <= prev_g_nxt;
    prev_use_r  <= prev_use_nxt;
    blk_r       <= blk_nxt;
    bg_r        <= bg_nxt;
    it_head_r   <= it_head_nxt;
    it_r        <= it_nxt;
    it_g_r      <= it_g_nxt;
    it_use_r    <= it_use_nxt;
    nx_r        <= nx_nxt;
    link_b_r    <= link_b_nxt;
    merged_r    <= merged_nxt;
    split_r     <= split_nxt;
    granted_r   <= granted_nxt;
    oofs_r      <= oofs_nxt;
    ook_r       <= ook_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    list_head_nxt = list_head_r;
    need_nxt      = need_r;
    cur_nxt       = cur_r;
    cur_g_nxt     = cur_g_r;
    cur_link_nxt  = cur_link_r;
    prev_head_nxt = prev_head_r;
    prev_nxt      = prev_r;
    prev_g_nxt    = prev_g_r;
    prev_use_nxt  = prev_use_r;
    blk_nxt       = blk_r;
    bg_nxt        = bg_r;
    it_head_nxt   = it_head_r;
    it_nxt        = it_r;
    it_g_nxt      = it_g_r;
    it_use_nxt    = it_use_r;
    nx_nxt        = nx_r;
    link_b_nxt    = link_b_r;
    merged_nxt    = merged_r;
    split_nxt     = split_r;
    granted_nxt   = granted_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    oofs_nxt      = oofs_r;
    ook_nxt       = ook_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = cur_r;
    ram_wdata     = '0;
    rem_g         = cur_g_r - need_r;
    sum_a         = {1'b0, LW'(it_r)} + {1'b0, it_g_r};
    sum_b         = {1'b0, LW'(blk_r)} + {1'b0, bg_r};
    ofs_full      = (32'(cur_r) << LGG) + 32'(HeaderBytes);

    case (state_r)
      ffha_pkg::ST_CLEAR: begin
        // Sweep every header: granule zero holds the heap, end marker is empty
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        if (clr_cnt_r == '0) begin
          ram_wdata = {1'b0, END_LINK, END_LINK};
        end else if (clr_cnt_r == GW'(EndGranule)) begin
          ram_wdata = {1'b0, LINK_EMPTY, {LW{1'b0}}};
        end else begin
          ram_wdata = '0;
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == GW'(GranuleCount - 1)) begin
          state_nxt = ffha_pkg::ST_IDLE;
        end
      end

      ffha_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          granted_nxt = '0;
          if (in_tuser == ffha_pkg::KIND_ALLOC) begin
            need_nxt      = chk_need;
            prev_head_nxt = 1'b1;
            cur_nxt       = list_head_r[GW-1:0];
            if (chk.alloc_bad || list_head_r[LW-1]) begin
              ovalid_nxt = 1'b1;
              oofs_nxt   = '0;
              ook_nxt    = 1'b0;
            end else begin
              state_nxt = ffha_pkg::ST_A_RD;
            end
          end else begin
            blk_nxt = chk_hdr;
            if (chk.free_bad) begin
              ovalid_nxt = 1'b1;
              oofs_nxt   = '0;
              ook_nxt    = 1'b0;
            end else begin
              state_nxt = ffha_pkg::ST_F_RD;
            end
          end
        end
      end

      ffha_pkg::ST_A_RD: begin
        ram_re    = 1'b1;
        ram_addr  = cur_r;
        state_nxt = ffha_pkg::ST_A_CHK;
      end

      ffha_pkg::ST_A_CHK: begin
        if ((rd_g < need_r) && (rd_link != LINK_EMPTY)) begin
          // Too small: advance along the list
          prev_nxt      = cur_r;
          prev_g_nxt    = rd_g;
          prev_use_nxt  = rd_use;
          prev_head_nxt = 1'b0;
          cur_nxt       = rd_link[GW-1:0];
          state_nxt     = ffha_pkg::ST_A_RD;
        end else if ((LW'(cur_r) == END_LINK) || (rd_g < need_r)) begin
          ovalid_nxt = 1'b1;
          oofs_nxt   = '0;
          ook_nxt    = 1'b0;
          state_nxt  = ffha_pkg::ST_IDLE;
        end else begin
          cur_g_nxt    = rd_g;
          cur_link_nxt = rd_link;
          granted_nxt  = ofs_full[13:0];
          state_nxt    = ffha_pkg::ST_A_SET;
        end
      end

      ffha_pkg::ST_A_SET: begin
        // Unlink the found block from its predecessor
        if (prev_head_r) begin
          list_head_nxt = cur_link_r;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = prev_r;
          ram_wdata = {prev_use_r, cur_link_r, prev_g_r};
        end
        state_nxt = ffha_pkg::ST_A_SPL;
      end

      ffha_pkg::ST_A_SPL: begin
        split_nxt = 1'b0;
        if ((rem_g > LW'(MinSplit)) &&
            (({1'b0, LW'(cur_r)} + {1'b0, need_r}) < (LW+1)'(GranuleCount))) begin
          ram_we    = 1'b1;
          ram_addr  = cur_r + need_r[GW-1:0];
          ram_wdata = {1'b0, LINK_EMPTY, rem_g};
          blk_nxt   = cur_r + need_r[GW-1:0];
          bg_nxt    = rem_g;
          cur_g_nxt = need_r;
          split_nxt = 1'b1;
        end
        state_nxt = ffha_pkg::ST_A_WCUR;
      end

      ffha_pkg::ST_A_WCUR: begin
        ram_we    = 1'b1;
        ram_addr  = cur_r;
        ram_wdata = {1'b1, LINK_EMPTY, cur_g_r};
        if (split_r) begin
          it_head_nxt = 1'b1;
          nx_nxt      = list_head_r;
          state_nxt   = ffha_pkg::ST_I_WALK;
        end else begin
          ovalid_nxt = 1'b1;
          oofs_nxt   = granted_r;
          ook_nxt    = 1'b1;
          state_nxt  = ffha_pkg::ST_IDLE;
        end
      end

      ffha_pkg::ST_F_RD: begin
        ram_re    = 1'b1;
        ram_addr  = blk_r;
        state_nxt = ffha_pkg::ST_F_CHK;
      end

      ffha_pkg::ST_F_CHK: begin
        // Only a block in use with an empty link may be released
        if (!rd_use || (rd_link != LINK_EMPTY)) begin
          ovalid_nxt = 1'b1;
          oofs_nxt   = '0;
          ook_nxt    = 1'b0;
          state_nxt  = ffha_pkg::ST_IDLE;
        end else begin
          bg_nxt    = rd_g;
          state_nxt = ffha_pkg::ST_F_WHDR;
        end
      end

      ffha_pkg::ST_F_WHDR: begin
        ram_we      = 1'b1;
        ram_addr    = blk_r;
        ram_wdata   = {1'b0, LINK_EMPTY, bg_r};
        it_head_nxt = 1'b1;
        nx_nxt      = list_head_r;
        state_nxt   = ffha_pkg::ST_I_WALK;
      end

      ffha_pkg::ST_I_WALK: begin
        // Find the last free block below the one being inserted
        if (!nx_r[LW-1] && (nx_r[GW-1:0] < blk_r)) begin
          it_nxt    = nx_r[GW-1:0];
          ram_re    = 1'b1;
          ram_addr  = nx_r[GW-1:0];
          state_nxt = ffha_pkg::ST_I_LD;
        end else begin
          state_nxt = ffha_pkg::ST_I_MRG;
        end
      end

      ffha_pkg::ST_I_LD: begin
        it_g_nxt    = rd_g;
        it_use_nxt  = rd_use;
        nx_nxt      = rd_link;
        it_head_nxt = 1'b0;
        state_nxt   = ffha_pkg::ST_I_WALK;
      end

      ffha_pkg::ST_I_MRG: begin
        // Merge into the lower neighbour when it ends where this block starts
        merged_nxt = 1'b0;
        if (!it_head_r && (sum_a == {1'b0, LW'(blk_r)})) begin
          bg_nxt     = bg_r + it_g_r;
          blk_nxt    = it_r;
          merged_nxt = 1'b1;
        end
        state_nxt = ffha_pkg::ST_I_NXT;
      end

      ffha_pkg::ST_I_NXT: begin
        if ((sum_b == {1'b0, nx_r}) && (nx_r != END_LINK) && !nx_r[LW-1]) begin
          ram_re    = 1'b1;
          ram_addr  = nx_r[GW-1:0];
          state_nxt = ffha_pkg::ST_I_NXM;
        end else begin
          link_b_nxt = nx_r;
          state_nxt  = ffha_pkg::ST_I_WBLK;
        end
      end

      ffha_pkg::ST_I_NXM: begin
        // Absorb the upper neighbour
        bg_nxt     = bg_r + rd_g;
        link_b_nxt = rd_link;
        state_nxt  = ffha_pkg::ST_I_WBLK;
      end

      ffha_pkg::ST_I_WBLK: begin
        ram_we    = 1'b1;
        ram_addr  = blk_r;
        ram_wdata = {merged_r ? it_use_r : 1'b0, link_b_r, bg_r};
        if (merged_r) begin
          ovalid_nxt = 1'b1;
          oofs_nxt   = granted_r;
          ook_nxt    = 1'b1;
          state_nxt  = ffha_pkg::ST_IDLE;
        end else begin
          state_nxt = ffha_pkg::ST_I_WIT;
        end
      end

      ffha_pkg::ST_I_WIT: begin
        // Point the predecessor at the inserted block
        if (it_head_r) begin
          list_head_nxt = LW'(blk_r);
        end else begin
          ram_we    = 1'b1;
          ram_addr  = it_r;
          ram_wdata = {it_use_r, LW'(blk_r), it_g_r};
        end
        ovalid_nxt = 1'b1;
        oofs_nxt   = granted_r;
        ook_nxt    = 1'b1;
        state_nxt  = ffha_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = ffha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
